/* hdl/bt709c_pkg.sv */
package bt709c_pkg;

    typedef enum logic {
        ACT_FWD = 1'b0,
        ACT_INV = 1'b1
    } t_act;

    typedef struct packed {
        t_act act;
        logic last;
    } t_ctl;

    // Q2.16 coefficients and reciprocals
    localparam logic signed [17:0] K_R  = 18'sd13933;
    localparam logic signed [17:0] K_G  = 18'sd46871;
    localparam logic signed [17:0] K_B  = 18'sd4732;
    localparam logic signed [17:0] K_CB = 18'sd35318;
    localparam logic signed [17:0] K_CR = 18'sd41615;
    localparam logic signed [17:0] K_RV = 18'sd103206;
    localparam logic signed [17:0] K_BV = 18'sd121607;
    localparam logic signed [17:0] K_IG = 18'sd91633;

endpackage

/* hdl/bt709c_lin.sv */
module bt709c_lin #(
    parameter int COMP_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bt709c_pkg::t_ctl              i_ctl,
    input  logic [COMP_BITS-1:0]          i_a,
    input  logic [COMP_BITS-1:0]          i_b,
    input  logic [COMP_BITS-1:0]          i_c,
    output bt709c_pkg::t_ctl              o_ctl,
    output logic signed [COMP_BITS+18:0]  o_s0,
    output logic signed [COMP_BITS+18:0]  o_s1,
    output logic signed [COMP_BITS+18:0]  o_s2
);
    import bt709c_pkg::*;

    localparam int WA = COMP_BITS + 19;
    localparam logic signed [WA-1:0] HALF = WA'(2 ** (COMP_BITS - 1));

    logic signed [WA-1:0] a_x, b_x, c_x, ys;
    logic signed [WA-1:0] n_s0, n_s1, n_s2;
    logic signed [WA-1:0] r_s0, r_s1, r_s2;
    t_ctl                 r_ctl;

    assign a_x = WA'($signed({1'b0, i_a}));
    assign b_x = WA'($signed({1'b0, i_b}));
    assign c_x = WA'($signed({1'b0, i_c}));

    always_comb begin
        ys = K_R * a_x + K_G * b_x + K_B * c_x;
        if (i_ctl.act == ACT_INV) begin
            // s0: R accumulator, s1: Y scaled, s2: B accumulator
            n_s0 = (a_x <<< 16) + K_RV * (c_x - HALF);
            n_s1 = a_x <<< 16;
            n_s2 = (a_x <<< 16) + K_BV * (b_x - HALF);
        end else begin
            n_s0 = ys;
            n_s1 = (c_x <<< 16) - ys;
            n_s2 = (a_x <<< 16) - ys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s0  = r_s0;
    assign o_s1  = r_s1;
    assign o_s2  = r_s2;

endmodule

/* hdl/bt709c_mix.sv */
module bt709c_mix #(
    parameter int COMP_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bt709c_pkg::t_ctl              i_ctl,
    input  logic signed [COMP_BITS+18:0]  i_s0,
    input  logic signed [COMP_BITS+18:0]  i_s1,
    input  logic signed [COMP_BITS+18:0]  i_s2,
    output bt709c_pkg::t_ctl              o_ctl,
    output logic signed [COMP_BITS+18:0]  o_p0,
    output logic signed [COMP_BITS+35:0]  o_p1,
    output logic signed [COMP_BITS+35:0]  o_p2
);
    import bt709c_pkg::*;

    localparam int WA = COMP_BITS + 19;
    localparam int WB = COMP_BITS + 36;

    logic signed [WB-1:0] s0_x, s1_x, s2_x;
    logic signed [WB-1:0] n_p1, n_p2;
    logic signed [WA-1:0] r_p0;
    logic signed [WB-1:0] r_p1, r_p2;
    t_ctl                 r_ctl;

    assign s0_x = WB'(i_s0);
    assign s1_x = WB'(i_s1);
    assign s2_x = WB'(i_s2);

    always_comb begin
        if (i_ctl.act == ACT_INV) begin
            // green numerator at scale 2^32
            n_p1 = (s1_x <<< 16) - K_R * s0_x - K_B * s2_x;
            n_p2 = s2_x;
        end else begin
            n_p1 = s1_x * K_CB;
            n_p2 = s2_x * K_CR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_p0  <= i_s0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
        end
    end

    assign o_ctl = r_ctl;
    assign o_p0  = r_p0;
    assign o_p1  = r_p1;
    assign o_p2  = r_p2;

endmodule

/* hdl/bt709c_rnd.sv */
module bt709c_rnd #(
    parameter int COMP_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bt709c_pkg::t_ctl              i_ctl,
    input  logic signed [COMP_BITS+18:0]  i_p0,
    input  logic signed [COMP_BITS+35:0]  i_p1,
    input  logic signed [COMP_BITS+35:0]  i_p2,
    output bt709c_pkg::t_ctl              o_ctl,
    output logic signed [COMP_BITS+5:0]   o_v0,
    output logic signed [COMP_BITS+37:0]  o_q1,
    output logic signed [COMP_BITS+5:0]   o_v2
);
    import bt709c_pkg::*;

    localparam int WA = COMP_BITS + 19;
    localparam int WB = COMP_BITS + 36;
    localparam int WG = COMP_BITS + 38;
    localparam int WR = COMP_BITS + 6;

    localparam logic signed [WA-1:0] RA16   = WA'(32768);
    localparam logic signed [WB-1:0] RB16   = WB'(32768);
    localparam logic signed [WB-1:0] RB31   = WB'(1) <<< 31;
    localparam logic signed [WB-1:0] HALF_B = WB'(2 ** (COMP_BITS - 1));

    logic signed [WA-1:0] t0;
    logic signed [WB-1:0] t1, t2;
    logic signed [WG-1:0] gn;
    logic signed [WR-1:0] n_v0, n_v2;
    logic signed [WG-1:0] n_q1;
    logic signed [WR-1:0] r_v0, r_v2;
    logic signed [WG-1:0] r_q1;
    t_ctl                 r_ctl;

    always_comb begin
        t0   = (i_p0 + RA16) >>> 16;
        n_v0 = WR'(t0);
        if (i_ctl.act == ACT_INV) begin
            t1   = (i_p1 + RB16) >>> 16;
            gn   = WG'(t1);
            n_q1 = gn * K_IG;
            t2   = (i_p2 + RB16) >>> 16;
        end else begin
            t1   = ((i_p1 + RB31) >>> 32) + HALF_B;
            gn   = WG'(t1);
            n_q1 = gn;
            t2   = ((i_p2 + RB31) >>> 32) + HALF_B;
        end
        n_v2 = WR'(t2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_v0  <= n_v0;
            r_q1  <= n_q1;
            r_v2  <= n_v2;
        end
    end

    assign o_ctl = r_ctl;
    assign o_v0  = r_v0;
    assign o_q1  = r_q1;
    assign o_v2  = r_v2;

endmodule

/* hdl/bt709c_out.sv */
module bt709c_out #(
    parameter int COMP_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bt709c_pkg::t_ctl              i_ctl,
    input  logic signed [COMP_BITS+5:0]   i_v0,
    input  logic signed [COMP_BITS+37:0]  i_q1,
    input  logic signed [COMP_BITS+5:0]   i_v2,
    output logic [COMP_BITS-1:0]          o_c0,
    output logic [COMP_BITS-1:0]          o_c1,
    output logic [COMP_BITS-1:0]          o_c2,
    output logic                          o_last
);
    import bt709c_pkg::*;

    localparam int WG = COMP_BITS + 38;
    localparam int WR = COMP_BITS + 6;

    localparam logic signed [WG-1:0] RG31 = WG'(1) <<< 31;
    localparam logic signed [WR-1:0] CMAX = WR'((2 ** COMP_BITS) - 1);

    logic signed [WG-1:0]  t1;
    logic signed [WR-1:0]  v1;
    logic [COMP_BITS-1:0]  n_c0, n_c1, n_c2;
    logic [COMP_BITS-1:0]  r_c0, r_c1, r_c2;
    logic                  r_last;

    function automatic logic [COMP_BITS-1:0] clampc(input logic signed [WR-1:0] v);
        logic [COMP_BITS-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > CMAX) begin
            res = '1;
        end else begin
            res = v[COMP_BITS-1:0];
        end
        return res;
    endfunction

    always_comb begin
        if (i_ctl.act == ACT_INV) begin
            t1 = (i_q1 + RG31) >>> 32;
        end else begin
            t1 = i_q1;
        end
        v1   = WR'(t1);
        n_c0 = clampc(i_v0);
        n_c1 = clampc(v1);
        n_c2 = clampc(i_v2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0   <= n_c0;
            r_c1   <= n_c1;
            r_c2   <= n_c2;
            r_last <= i_ctl.last;
        end
    end

    assign o_c0   = r_c0;
    assign o_c1   = r_c1;
    assign o_c2   = r_c2;
    assign o_last = r_last;

endmodule

/* hdl/bt709_rgb_ycbcr_converter.sv */
// BT.709 full-range colour converter. tuser = 0 takes R, G, B and gives Y, Cb, Cr
// (Cb and Cr offset by one half); tuser = 1 takes Y, Cb, Cr and gives R, G, B.
// Components are unsigned COMP_BITS-bit fractions, all results rounded half-up and
// clamped to the component range; tlast is carried alongside each pixel. One
// pixel per clock is accepted and delivered while m_axis_tready is high; each
// accepted request passes through the four register stages (linear
// combination, coefficient products, rounding with the green reciprocal product,
// final rounding and clamp into the output register). Back-pressure ripples up
// the stages, so bubbles are squeezed out before s_axis_tready drops.
module bt709_rgb_ycbcr_converter #(
    parameter int COMP_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // comp_first, comp_second, comp_third, zero pad to bytes
    input  logic [((3*COMP_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // action
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_first, out_second, out_third, zero pad to bytes
    output logic [((3*COMP_BITS+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import bt709c_pkg::*;

    localparam int TDW = ((3 * COMP_BITS + 7) / 8) * 8;

    logic r_va, r_vb, r_vc, r_vd;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    t_ctl in_ctl, ctl_a, ctl_b, ctl_c;

    logic signed [COMP_BITS+18:0] s0, s1, s2, p0;
    logic signed [COMP_BITS+35:0] p1, p2;
    logic signed [COMP_BITS+5:0]  v0, v2;
    logic signed [COMP_BITS+37:0] q1;
    logic [COMP_BITS-1:0]         c0, c1, c2;

    // a stage loads when empty or when its contents move on
    assign rdy_d = !r_vd || m_axis_tready;
    assign rdy_c = !r_vc || rdy_d;
    assign rdy_b = !r_vb || rdy_c;
    assign rdy_a = !r_va || rdy_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= s_axis_tvalid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_comb begin
        in_ctl.act  = t_act'(s_axis_tuser);
        in_ctl.last = s_axis_tlast;
    end

    bt709c_lin #(.COMP_BITS(COMP_BITS)) u_lin (
        .i_clk (i_clk),
        .i_en  (rdy_a),
        .i_ctl (in_ctl),
        .i_a   (s_axis_tdata[COMP_BITS-1:0]),
        .i_b   (s_axis_tdata[2*COMP_BITS-1:COMP_BITS]),
        .i_c   (s_axis_tdata[3*COMP_BITS-1:2*COMP_BITS]),
        .o_ctl (ctl_a),
        .o_s0  (s0),
        .o_s1  (s1),
        .o_s2  (s2)
    );

    bt709c_mix #(.COMP_BITS(COMP_BITS)) u_mix (
        .i_clk (i_clk),
        .i_en  (rdy_b),
        .i_ctl (ctl_a),
        .i_s0  (s0),
        .i_s1  (s1),
        .i_s2  (s2),
        .o_ctl (ctl_b),
        .o_p0  (p0),
        .o_p1  (p1),
        .o_p2  (p2)
    );

    bt709c_rnd #(.COMP_BITS(COMP_BITS)) u_rnd (
        .i_clk (i_clk),
        .i_en  (rdy_c),
        .i_ctl (ctl_b),
        .i_p0  (p0),
        .i_p1  (p1),
        .i_p2  (p2),
        .o_ctl (ctl_c),
        .o_v0  (v0),
        .o_q1  (q1),
        .o_v2  (v2)
    );

    bt709c_out #(.COMP_BITS(COMP_BITS)) u_out (
        .i_clk  (i_clk),
        .i_en   (rdy_d),
        .i_ctl  (ctl_c),
        .i_v0   (v0),
        .i_q1   (q1),
        .i_v2   (v2),
        .o_c0   (c0),
        .o_c1   (c1),
        .o_c2   (c2),
        .o_last (m_axis_tlast)
    );

    assign s_axis_tready = rdy_a;
    assign m_axis_tvalid = r_vd;
    assign m_axis_tdata  = TDW'({c2, c1, c0});

endmodule
